// File: rtl/core/krt_pkg.sv
// Shared types and constants for the keyed record table.
// Holds request and mark codes, the slot record layout and the controller
// to datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package krt_pkg;

    localparam int KRT_SLOTS = 1024;

    // field widths of the item channels
    localparam int REQ_W      = 3;
    localparam int ID_W       = 16;
    localparam int CAT_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 10;
    localparam int CNT_OUT_W  = 11;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 64;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SORT   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // slot marks
    localparam logic [1:0] MARK_FREE = 2'd0;
    localparam logic [1:0] MARK_USED = 2'd1;
    localparam logic [1:0] MARK_DEL  = 2'd2;

    typedef struct packed {
        logic [1:0]       mark;
        logic [ID_W-1:0]  id;
        logic [ID_W-1:0]  owner;
        logic [CAT_W-1:0] cat;
        logic             paused;
    } rec_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_EX,
        S_SRD0,
        S_SEX0,
        S_SRD,
        S_SEX,
        S_SFL,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_INIT_WR,
        CMD_READ,
        CMD_EXEC,
        CMD_SORT_LOAD,
        CMD_SORT_EXEC,
        CMD_SORT_FLUSH,
        CMD_RESULT
    } cmd_t;

    typedef struct packed {
        logic last;          // slot counter on the last slot
        logic hit;           // scan can stop: free slot or id match
        logic swapped;       // current sort pass moved something
        logic out_free;      // output register can take a result
        logic in_sort;       // offered item is a sort
        logic in_quick;      // offered item needs no scan
        logic next_id_zero;  // id counter exhausted
    } dp_status_t;

endpackage

// File: rtl/core/keyed_record_table.sv
// Top level of the keyed record table: controller plus datapath.
// Depends on krt_pkg, krt_ctrl and krt_dpath.
`timescale 1ns / 1ps

// Usage
//   Input channel s_*: one request item per handshake. s_tuser carries the
//   request code, s_tdata the key, owner, category and paused fields.
//   Result channel m_*: exactly one result item per request, in order.
//   m_tuser carries the status, m_tdata the result fields.
// Operation
//   Requests are taken one at a time. A scan reads the slots one by one
//   through the single slot memory port, each read followed by an execute
//   step; clear, delete and count visit every slot, while insert and find
//   stop at the first hit. Requests that need no scan go straight to the result.
//   Sort runs bubble passes over all slots until a pass moves nothing, so
//   it takes between 1 and SLOTS passes.
// Reset
//   After aresetn rises the block writes every slot to zero/free, one slot
//   per cycle, with s_tready low. The id counter starts at 1.
// Stalls
//   The result register holds an item while m_tready is low; the next
//   request is accepted meanwhile and its result waits until the register
//   frees.
module keyed_record_table import krt_pkg::*; #(
    parameter int SLOTS = KRT_SLOTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [15:0] key_id, [31:16] owner_id, [39:32] category, [40] paused
    input  logic [S_DATA_W-1:0] s_tdata,
    // [2:0] req_type
    input  logic [REQ_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [9:0] slot_index, [25:10] record_id, [41:26] owner_out,
    // [49:42] category_out, [50] paused_out, [61:51] used_count, [62] moved
    output logic [M_DATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0] m_tuser
);

    cmd_t       cmd;
    dp_status_t st;

    krt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    krt_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .st       (st)
    );

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in progress");

    // a finished result always lands in the output register
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_RESULT) |=> m_tvalid)
        else $error("result not presented");

    // an exhausted id counter stays exhausted
    a_id_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        st.next_id_zero |=> st.next_id_zero)
        else $error("id counter left exhausted state");

endmodule

// File: rtl/core/krt_ctrl.sv
// Sequencer for the keyed record table.
// Steps the slot scans, sort passes and reset fill. Uses krt_pkg.
`timescale 1ns / 1ps

module krt_ctrl import krt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t st,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd = CMD_INIT_WR;
                if (st.last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd = CMD_ACCEPT;
                    if (st.in_quick)     state_next = S_DONE;
                    else if (st.in_sort) state_next = S_SRD0;
                    else                 state_next = S_RD;
                end
            end
            S_RD: begin
                cmd        = CMD_READ;
                state_next = S_EX;
            end
            S_EX: begin
                cmd = CMD_EXEC;
                if (st.hit || st.last) state_next = S_DONE;
                else                   state_next = S_RD;
            end
            S_SRD0: begin
                cmd        = CMD_READ;
                state_next = S_SEX0;
            end
            S_SEX0: begin
                cmd        = CMD_SORT_LOAD;
                state_next = S_SRD;
            end
            S_SRD: begin
                cmd        = CMD_READ;
                state_next = S_SEX;
            end
            S_SEX: begin
                cmd = CMD_SORT_EXEC;
                if (st.last) state_next = S_SFL;
                else         state_next = S_SRD;
            end
            S_SFL: begin
                cmd = CMD_SORT_FLUSH;
                if (st.swapped) state_next = S_SRD0;
                else            state_next = S_DONE;
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd        = CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

endmodule

// File: rtl/core/krt_dpath.sv
// Datapath of the keyed record table: slot memory, slot counter, sort
// carry register, id counter and the result register. Uses krt_pkg.
`timescale 1ns / 1ps

module krt_dpath import krt_pkg::*; #(
    parameter int SLOTS = KRT_SLOTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [REQ_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0] m_tuser,
    input  cmd_t                cmd,
    output dp_status_t          st
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    rec_t mem [SLOTS];

    rec_t             rd_reg, carry_reg;
    logic [IDX_W-1:0] idx_reg, fidx_reg;
    logic [REQ_W-1:0] req_reg;
    logic [ID_W-1:0]  key_reg, own_reg, rid_reg, fown_reg, next_id_reg;
    logic [CAT_W-1:0] cat_reg, fcat_reg;
    logic             pau_reg, fpau_reg;
    logic             found_reg, del_reg, swapped_reg, moved_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [STATUS_W-1:0] m_user_reg;

    logic [REQ_W-1:0] in_req;
    logic [ID_W-1:0]  in_key;
    logic             used, hit_ins, hit_find, del_match, goes_after;
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic [STATUS_W-1:0] status;

    assign in_req = s_tuser;
    assign in_key = s_tdata[15:0];

    assign used      = (rd_reg.mark == MARK_USED);
    assign hit_ins   = (req_reg == REQ_INSERT) && (rd_reg.mark == MARK_FREE);
    assign hit_find  = (req_reg == REQ_FIND) && used && (rd_reg.id == key_reg);
    assign del_match = (req_reg == REQ_DELETE) && used && (rd_reg.owner == own_reg);
    // stable order: carry goes behind the newly read slot only if strictly greater
    assign goes_after = (carry_reg.owner > rd_reg.owner) ||
                        ((carry_reg.owner == rd_reg.owner) && (carry_reg.cat > rd_reg.cat));

    assign st.last         = (idx_reg == IDX_W'(SLOTS - 1));
    assign st.hit          = hit_ins || hit_find;
    assign st.swapped      = swapped_reg;
    assign st.out_free     = !m_valid_reg || m_tready;
    assign st.in_sort      = (in_req == REQ_SORT);
    assign st.in_quick     = (in_req > REQ_SORT) ||
                             ((in_req == REQ_INSERT) && (next_id_reg == '0)) ||
                             ((in_req == REQ_FIND) && (in_key == '0));
    assign st.next_id_zero = (next_id_reg == '0);

    // memory write selection
    always_comb begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = rd_reg;
        case (cmd)
            CMD_INIT_WR: begin
                we    = 1'b1;
                wdata = '0;
            end
            CMD_EXEC: begin
                if (req_reg == REQ_CLEAR) begin
                    we         = 1'b1;
                    wdata.mark = MARK_FREE;
                end else if (hit_ins) begin
                    we    = 1'b1;
                    wdata = '{mark: MARK_USED, id: next_id_reg, owner: own_reg,
                              cat: cat_reg, paused: pau_reg};
                end else if (del_match) begin
                    we         = 1'b1;
                    wdata.mark = MARK_DEL;
                end
            end
            CMD_SORT_EXEC: begin
                we    = 1'b1;
                waddr = idx_reg - 1'b1;
                wdata = goes_after ? rd_reg : carry_reg;
            end
            CMD_SORT_FLUSH: begin
                we    = 1'b1;
                waddr = IDX_W'(SLOTS - 1);
                wdata = carry_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (cmd == CMD_READ) rd_reg <= mem[idx_reg];
    end

    // scan state and accumulated result fields
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            next_id_reg <= ID_W'(1);
        end else begin
            case (cmd) inside
                CMD_ACCEPT: idx_reg <= '0;
                CMD_INIT_WR, CMD_EXEC, CMD_SORT_LOAD, CMD_SORT_EXEC: idx_reg <= idx_reg + 1'b1;
                CMD_SORT_FLUSH: idx_reg <= '0;
                default: ;
            endcase
            if (cmd == CMD_EXEC && hit_ins) next_id_reg <= next_id_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_ACCEPT: begin
                req_reg   <= in_req;
                key_reg   <= in_key;
                own_reg   <= s_tdata[31:16];
                cat_reg   <= s_tdata[39:32];
                pau_reg   <= s_tdata[40];
                found_reg <= 1'b0;
                fidx_reg  <= '0;
                rid_reg   <= '0;
                fown_reg  <= '0;
                fcat_reg  <= '0;
                fpau_reg  <= 1'b0;
                del_reg   <= 1'b0;
                cnt_reg   <= '0;
                moved_reg <= 1'b0;
            end
            CMD_EXEC: begin
                if (hit_ins) begin
                    found_reg <= 1'b1;
                    fidx_reg  <= idx_reg;
                    rid_reg   <= next_id_reg;
                end
                if (hit_find) begin
                    found_reg <= 1'b1;
                    fidx_reg  <= idx_reg;
                    rid_reg   <= rd_reg.id;
                    fown_reg  <= rd_reg.owner;
                    fcat_reg  <= rd_reg.cat;
                    fpau_reg  <= rd_reg.paused;
                end
                if (del_match) del_reg <= 1'b1;
                if (req_reg == REQ_COUNT && used) cnt_reg <= cnt_reg + 1'b1;
            end
            CMD_SORT_LOAD: begin
                carry_reg   <= rd_reg;
                swapped_reg <= 1'b0;
            end
            CMD_SORT_EXEC: begin
                if (goes_after) begin
                    swapped_reg <= 1'b1;
                    moved_reg   <= 1'b1;
                end else begin
                    carry_reg <= rd_reg;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        case (req_reg)
            REQ_CLEAR:  status = ST_OK;
            REQ_INSERT: status = found_reg ? ST_OK : ST_FULL;
            REQ_FIND:   status = found_reg ? ST_OK : ST_NONE;
            REQ_DELETE: status = del_reg ? ST_OK : ST_NONE;
            REQ_COUNT:  status = (cnt_reg != '0) ? ST_OK : ST_NONE;
            REQ_SORT:   status = ST_OK;
            default:    status = ST_NONE;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd == CMD_RESULT) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd == CMD_RESULT) begin
            m_user_reg <= status;
            m_data_reg <= {1'b0, moved_reg, CNT_OUT_W'(cnt_reg), fpau_reg, fcat_reg,
                           fown_reg, rid_reg, SLOT_OUT_W'(fidx_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
